// File: src/prp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_pkg
// Shared constants, register codes, types and the saturation helper of the
// pinhole projection unit.
// ----------------------------------------------------------------------------
package prp_pkg;

  // Pipeline geometry
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DIV_LAT     = DIV_STEPS + 2;
  localparam int unsigned DIST_LAT    = 6;
  localparam int unsigned TAIL_STAGES = 4;
  localparam int unsigned TOTAL_LAT   = 3 + 2 * DIV_LAT + DIST_LAT + TAIL_STAGES;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFS_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_K2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd6;

  // Register reset values
  localparam logic [30:0] FOCAL_RST  = 31'd65536000;
  localparam logic [15:0] WIDTH_RST  = 16'd1920;
  localparam logic [15:0] HEIGHT_RST = 16'd1080;

  // Action and status codes
  localparam logic ACT_PROJECT   = 1'b0;
  localparam logic ACT_UNPROJECT = 1'b1;
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Q8.24 one
  localparam logic signed [63:0] Q24_ONE = 64'sd16777216;

  typedef struct packed {
    logic [30:0] focal;
    logic [31:0] ofs_x;
    logic [31:0] ofs_y;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [15:0] width;
    logic [15:0] height;
  } cfg_t;

  // Clamp to signed 32 bits: {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -64'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end else begin
      return {1'b0, v[31:0]};
    end
  endfunction

endpackage

// File: src/prp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_cfg
// Configuration register file: decodes indexed writes into the camera
// parameters.
// ----------------------------------------------------------------------------
module prp_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [prp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i,
  output prp_pkg::cfg_t                      cfg_o
);

  prp_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prp_pkg::REG_FOCAL:  cfg_d.focal  = cfg_wdata_i[30:0];
        prp_pkg::REG_OFS_X:  cfg_d.ofs_x  = cfg_wdata_i;
        prp_pkg::REG_OFS_Y:  cfg_d.ofs_y  = cfg_wdata_i;
        prp_pkg::REG_K1:     cfg_d.k1     = cfg_wdata_i;
        prp_pkg::REG_K2:     cfg_d.k2     = cfg_wdata_i;
        prp_pkg::REG_WIDTH:  cfg_d.width  = cfg_wdata_i[15:0];
        prp_pkg::REG_HEIGHT: cfg_d.height = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal  <= prp_pkg::FOCAL_RST;
      cfg_q.ofs_x  <= '0;
      cfg_q.ofs_y  <= '0;
      cfg_q.k1     <= '0;
      cfg_q.k2     <= '0;
      cfg_q.width  <= prp_pkg::WIDTH_RST;
      cfg_q.height <= prp_pkg::HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: src/prp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_div
// Pipelined restoring divider, one quotient bit per stage, with a saturated
// signed 32 bit result. Magnitudes in, sign applied at the end.
// ----------------------------------------------------------------------------
module prp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [55:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic        neg_i,
  output logic        valid_o,
  output logic [31:0] quot_o,
  output logic        sat_o
);

  localparam int unsigned N = prp_pkg::DIV_STEPS;

  logic [N:0]  vld_q;
  logic [N:0]  ovf_q;
  logic [N:0]  neg_q;
  logic [31:0] rem_q  [N+1];
  logic [31:0] low_q  [N+1];
  logic [31:0] quot_q [N+1];
  logic [31:0] dvs_q  [N+1];
  logic [32:0] trial  [N];
  logic [31:0] rem_d  [N];
  logic [31:0] quot_d [N];
  logic [31:0] mag;
  logic        sat_d;
  logic [31:0] res_d;
  logic        out_vld_q;
  logic [31:0] out_quot_q;
  logic        out_sat_q;

  // One trial subtraction per stage
  always_comb begin
    for (int k = 0; k < N; k++) begin
      trial[k] = {rem_q[k], low_q[k][31]};
      if (trial[k] >= {1'b0, dvs_q[k]}) begin
        rem_d[k]  = 32'(trial[k] - {1'b0, dvs_q[k]});
        quot_d[k] = {quot_q[k][30:0], 1'b1};
      end else begin
        rem_d[k]  = trial[k][31:0];
        quot_d[k] = {quot_q[k][30:0], 1'b0};
      end
    end
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[N-1:0], valid_i};
      out_vld_q <= vld_q[N];
    end
  end

  // Advance the partial remainders; the top dividend bits seed the remainder
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= 32'(dividend_i[55:32]);
    low_q[0]  <= dividend_i[31:0];
    quot_q[0] <= '0;
    dvs_q[0]  <= divisor_i;
    ovf_q[0]  <= 32'(dividend_i[55:32]) >= divisor_i;
    neg_q[0]  <= neg_i;
    for (int k = 0; k < N; k++) begin
      rem_q[k+1]  <= rem_d[k];
      low_q[k+1]  <= {low_q[k][30:0], 1'b0};
      quot_q[k+1] <= quot_d[k];
      dvs_q[k+1]  <= dvs_q[k];
      ovf_q[k+1]  <= ovf_q[k];
      neg_q[k+1]  <= neg_q[k];
    end
  end

  // Apply the sign and clamp
  assign mag = quot_q[N];
  always_comb begin
    if (neg_q[N]) begin
      sat_d = ovf_q[N] || (mag > 32'h8000_0000);
      res_d = sat_d ? 32'h8000_0000 : 32'(-mag);
    end else begin
      sat_d = ovf_q[N] || (mag > 32'h7fff_ffff);
      res_d = sat_d ? 32'h7fff_ffff : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    out_quot_q <= res_d;
    out_sat_q  <= sat_d;
  end

  assign valid_o = out_vld_q;
  assign quot_o  = out_quot_q;
  assign sat_o   = out_sat_q;

`ifndef SYNTH
  // A quotient too large for 32 bits must come out clamped
  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && ovf_q[0] |-> ##(N+1) sat_o)
    else $error("prp_div: overflowed quotient not saturated");

  // The final remainder stays below the divisor
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[N] && !ovf_q[N] |-> rem_q[N] < dvs_q[N])
    else $error("prp_div: remainder not below divisor");
`endif

endmodule

// File: src/prp_distort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prp_distort
// Radial distortion factor 1 + k1*r2 + k2*r4 in Q8.24, six register stages,
// at most one multiplier level per stage.
// ----------------------------------------------------------------------------
module prp_distort (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic [31:0] k1_i,
  input  logic [31:0] k2_i,
  output logic        valid_o,
  output logic [31:0] l_o,
  output logic        sat_o
);

  logic [prp_pkg::DIST_LAT-1:0] vld_q;

  logic signed [63:0] xx_q, yy_q;
  logic [63:0]        sq;
  logic [30:0]        r2_q;
  logic               s2_q;
  logic [61:0]        r2sq_q;
  logic signed [63:0] k1r2_q;
  logic               s3_q;
  logic [30:0]        r4_q;
  logic signed [47:0] k1t_q;
  logic               s4_q;
  logic signed [63:0] k2r4_q;
  logic signed [47:0] k1t5_q;
  logic               s5_q;
  logic [32:0]        l_sat;
  logic [31:0]        l_q;
  logic               s6_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[prp_pkg::DIST_LAT-2:0], valid_i};
    end
  end

  assign sq    = 64'(xx_q) + 64'(yy_q);
  assign l_sat = prp_pkg::sat32(prp_pkg::Q24_ONE + 64'(k1t5_q)
                                + 64'($signed(k2r4_q[63:16])));

  // Square, sum, square again, weight and add
  always_ff @(posedge clk_i) begin
    xx_q   <= $signed(x_i) * $signed(x_i);
    yy_q   <= $signed(y_i) * $signed(y_i);

    s2_q   <= |sq[63:47];
    r2_q   <= (|sq[63:47]) ? 31'h7fff_ffff : sq[46:16];

    r2sq_q <= r2_q * r2_q;
    k1r2_q <= $signed(k1_i) * $signed({1'b0, r2_q});
    s3_q   <= s2_q;

    s4_q   <= s3_q || (|r2sq_q[61:47]);
    r4_q   <= (|r2sq_q[61:47]) ? 31'h7fff_ffff : r2sq_q[46:16];
    k1t_q  <= $signed(k1r2_q[63:16]);

    k2r4_q <= $signed(k2_i) * $signed({1'b0, r4_q});
    k1t5_q <= k1t_q;
    s5_q   <= s4_q;

    l_q    <= l_sat[31:0];
    s6_q   <= s5_q || l_sat[32];
  end

  assign valid_o = vld_q[prp_pkg::DIST_LAT-1];
  assign l_o     = l_q;
  assign sat_o   = s6_q;

endmodule

// File: src/pinhole_radial_projection.sv
// Throughput: one item per clock; busy_o stays low, start is always taken.
// The two 32-stage divider levels and the six-stage distortion chain set the depth.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Results are shown for one cycle with done_o; the receiver cannot stall.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pinhole_radial_projection
// Pinhole camera with k1/k2 radial distortion: projects 3D points to pixels
// or unprojects pixels to normalized rays, in saturating fixed point.
// ----------------------------------------------------------------------------
module pinhole_radial_projection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          action_i,
  input  logic signed [31:0]            point_x_i,
  input  logic signed [31:0]            point_y_i,
  input  logic signed [31:0]            point_z_i,
  input  logic signed [31:0]            pixel_u_i,
  input  logic signed [31:0]            pixel_v_i,
  output logic                          done_o,
  output logic signed [31:0]            result_x_o,
  output logic signed [31:0]            result_y_o,
  output logic [1:0]                    status_o
);

  typedef struct packed {
    logic act;
    logic zero;
  } sb1_t;

  typedef struct packed {
    logic        act;
    logic        zero;
    logic        sat;
    logic [31:0] x;
    logic [31:0] y;
  } sb2_t;

  typedef struct packed {
    logic        act;
    logic        zero;
    logic        sat;
    logic [31:0] rx;
    logic [31:0] ry;
  } sb3_t;

  prp_pkg::cfg_t cfg;
  logic [30:0]   halfw, halfh;

  // Input stage
  logic               a_vld_q;
  logic               a_act_q;
  logic signed [31:0] a_px_q, a_py_q, a_pz_q, a_pu_q, a_pv_q;

  // Numerator / denominator stage
  logic signed [34:0] nx_d, ny_d;
  logic signed [32:0] den_d;
  logic               zero_d;
  logic               b_vld_q, b_act_q, b_zero_q;
  logic signed [34:0] b_nx_q, b_ny_q;
  logic signed [32:0] b_den_q;
  logic [33:0]        mag_nx, mag_ny;
  logic [31:0]        mag_den;

  // First divider
  logic        q1_vld;
  logic [31:0] q1x, q1y;
  logic        q1sx, q1sy;
  sb1_t        sb1_q [prp_pkg::DIV_LAT];

  // Distortion
  logic        l_vld;
  logic [31:0] l_val;
  logic        l_sat;
  sb2_t        sb2_in;
  sb2_t        sb2_q [prp_pkg::DIST_LAT];

  // Tail stages
  logic               t1_vld_q, t1_act_q, t1_zero_q, t1_sat_q;
  logic signed [31:0] t1_x_q, t1_y_q, t1_l_q;
  logic signed [63:0] t1_xl_q, t1_yl_q;
  logic [32:0]        tx_sat, ty_sat;
  logic               t2_vld_q, t2_act_q, t2_zero_q, t2_sat_q;
  logic signed [31:0] t2_x_q, t2_y_q, t2_l_q, t2_tx_q, t2_ty_q;
  logic               t3_vld_q, t3_act_q, t3_zero_q, t3_sat_q;
  logic signed [31:0] t3_x_q, t3_y_q, t3_l_q;
  logic signed [63:0] t3_txf_q, t3_tyf_q;
  logic [32:0]        rx_sat, ry_sat;
  logic               t4_vld_q, t4_act_q, t4_zero_q, t4_sat_q;
  logic signed [31:0] t4_x_q, t4_y_q, t4_l_q, t4_rx_q, t4_ry_q;
  logic [31:0]        mag_x2, mag_y2, mag_l2;

  // Second divider
  logic        q2_vld;
  logic [31:0] q2x, q2y;
  logic        q2sx, q2sy;
  sb3_t        sb3_in;
  sb3_t        sb3_q [prp_pkg::DIV_LAT];
  sb3_t        sb3_out;

  // Output register
  logic        done_q;
  logic [31:0] res_x_d, res_y_d, res_x_q, res_y_q;
  logic [1:0]  status_d, status_q;

  prp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign halfw  = {cfg.width, 15'b0};
  assign halfh  = {cfg.height, 15'b0};
  assign busy_o = 1'b0;

  // Capture the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_act_q <= action_i;
    a_px_q  <= point_x_i;
    a_py_q  <= point_y_i;
    a_pz_q  <= point_z_i;
    a_pu_q  <= pixel_u_i;
    a_pv_q  <= pixel_v_i;
  end

  // Form the first quotient operands
  always_comb begin
    if (a_act_q == prp_pkg::ACT_UNPROJECT) begin
      nx_d   = 35'(a_pu_q) - 35'($signed(cfg.ofs_x)) - $signed(35'(halfw));
      ny_d   = 35'(a_pv_q) - 35'($signed(cfg.ofs_y)) - $signed(35'(halfh));
      den_d  = $signed(33'(cfg.focal));
      zero_d = (cfg.focal == '0);
    end else begin
      nx_d   = 35'(a_px_q);
      ny_d   = 35'(a_py_q);
      den_d  = 33'(a_pz_q);
      zero_d = (a_pz_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    b_act_q  <= a_act_q;
    b_zero_q <= zero_d;
    b_nx_q   <= nx_d;
    b_ny_q   <= ny_d;
    b_den_q  <= den_d;
  end

  assign mag_nx  = b_nx_q[34] ? 34'(-b_nx_q) : 34'(b_nx_q);
  assign mag_ny  = b_ny_q[34] ? 34'(-b_ny_q) : 34'(b_ny_q);
  assign mag_den = b_den_q[32] ? 32'(-b_den_q) : 32'(b_den_q);

  prp_div u_div1_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_vld_q),
    .dividend_i ({6'b0, mag_nx, 16'b0}),
    .divisor_i  (mag_den),
    .neg_i      (b_nx_q[34] ^ b_den_q[32]),
    .valid_o    (q1_vld),
    .quot_o     (q1x),
    .sat_o      (q1sx)
  );

  prp_div u_div1_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_vld_q),
    .dividend_i ({6'b0, mag_ny, 16'b0}),
    .divisor_i  (mag_den),
    .neg_i      (b_ny_q[34] ^ b_den_q[32]),
    .valid_o    (),
    .quot_o     (q1y),
    .sat_o      (q1sy)
  );

  // Carry the item tag alongside the first divider
  always_ff @(posedge clk_i) begin
    sb1_q[0] <= '{act: b_act_q, zero: b_zero_q};
    for (int k = 1; k < prp_pkg::DIV_LAT; k++) begin
      sb1_q[k] <= sb1_q[k-1];
    end
  end

  prp_distort u_distort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q1_vld),
    .x_i     (q1x),
    .y_i     (q1y),
    .k1_i    (cfg.k1),
    .k2_i    (cfg.k2),
    .valid_o (l_vld),
    .l_o     (l_val),
    .sat_o   (l_sat)
  );

  assign sb2_in = '{act:  sb1_q[prp_pkg::DIV_LAT-1].act,
                    zero: sb1_q[prp_pkg::DIV_LAT-1].zero,
                    sat:  q1sx | q1sy,
                    x:    q1x,
                    y:    q1y};

  // Carry the coordinates alongside the distortion chain
  always_ff @(posedge clk_i) begin
    sb2_q[0] <= sb2_in;
    for (int k = 1; k < prp_pkg::DIST_LAT; k++) begin
      sb2_q[k] <= sb2_q[k-1];
    end
  end

  // Tail valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q <= 1'b0;
      t2_vld_q <= 1'b0;
      t3_vld_q <= 1'b0;
      t4_vld_q <= 1'b0;
    end else begin
      t1_vld_q <= l_vld;
      t2_vld_q <= t1_vld_q;
      t3_vld_q <= t2_vld_q;
      t4_vld_q <= t3_vld_q;
    end
  end

  assign tx_sat = prp_pkg::sat32(t1_xl_q >>> 24);
  assign ty_sat = prp_pkg::sat32(t1_yl_q >>> 24);
  assign rx_sat = prp_pkg::sat32((t3_txf_q >>> 16) + 64'($signed(cfg.ofs_x))
                                 + $signed(64'(halfw)));
  assign ry_sat = prp_pkg::sat32((t3_tyf_q >>> 16) + 64'($signed(cfg.ofs_y))
                                 + $signed(64'(halfh)));

  // Project tail: scale by the factor, then by the focal length, shift and offset
  always_ff @(posedge clk_i) begin
    t1_act_q  <= sb2_q[prp_pkg::DIST_LAT-1].act;
    t1_zero_q <= sb2_q[prp_pkg::DIST_LAT-1].zero;
    t1_sat_q  <= sb2_q[prp_pkg::DIST_LAT-1].sat | l_sat;
    t1_x_q    <= sb2_q[prp_pkg::DIST_LAT-1].x;
    t1_y_q    <= sb2_q[prp_pkg::DIST_LAT-1].y;
    t1_l_q    <= l_val;
    t1_xl_q   <= $signed(sb2_q[prp_pkg::DIST_LAT-1].x) * $signed(l_val);
    t1_yl_q   <= $signed(sb2_q[prp_pkg::DIST_LAT-1].y) * $signed(l_val);

    t2_act_q  <= t1_act_q;
    t2_zero_q <= t1_zero_q;
    t2_sat_q  <= t1_sat_q |
                 ((t1_act_q == prp_pkg::ACT_PROJECT) & (tx_sat[32] | ty_sat[32]));
    t2_x_q    <= t1_x_q;
    t2_y_q    <= t1_y_q;
    t2_l_q    <= t1_l_q;
    t2_tx_q   <= tx_sat[31:0];
    t2_ty_q   <= ty_sat[31:0];

    t3_act_q  <= t2_act_q;
    t3_zero_q <= t2_zero_q;
    t3_sat_q  <= t2_sat_q;
    t3_x_q    <= t2_x_q;
    t3_y_q    <= t2_y_q;
    t3_l_q    <= t2_l_q;
    t3_txf_q  <= t2_tx_q * $signed({1'b0, cfg.focal});
    t3_tyf_q  <= t2_ty_q * $signed({1'b0, cfg.focal});

    t4_act_q  <= t3_act_q;
    t4_zero_q <= t3_zero_q |
                 ((t3_act_q == prp_pkg::ACT_UNPROJECT) & (t3_l_q == '0));
    t4_sat_q  <= t3_sat_q |
                 ((t3_act_q == prp_pkg::ACT_PROJECT) & (rx_sat[32] | ry_sat[32]));
    t4_x_q    <= t3_x_q;
    t4_y_q    <= t3_y_q;
    t4_l_q    <= t3_l_q;
    t4_rx_q   <= rx_sat[31:0];
    t4_ry_q   <= ry_sat[31:0];
  end

  assign mag_x2 = t4_x_q[31] ? 32'(-t4_x_q) : t4_x_q;
  assign mag_y2 = t4_y_q[31] ? 32'(-t4_y_q) : t4_y_q;
  assign mag_l2 = t4_l_q[31] ? 32'(-t4_l_q) : t4_l_q;

  prp_div u_div2_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (t4_vld_q),
    .dividend_i ({mag_x2, 24'b0}),
    .divisor_i  (mag_l2),
    .neg_i      (t4_x_q[31] ^ t4_l_q[31]),
    .valid_o    (q2_vld),
    .quot_o     (q2x),
    .sat_o      (q2sx)
  );

  prp_div u_div2_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (t4_vld_q),
    .dividend_i ({mag_y2, 24'b0}),
    .divisor_i  (mag_l2),
    .neg_i      (t4_y_q[31] ^ t4_l_q[31]),
    .valid_o    (),
    .quot_o     (q2y),
    .sat_o      (q2sy)
  );

  assign sb3_in = '{act: t4_act_q, zero: t4_zero_q, sat: t4_sat_q,
                    rx: t4_rx_q, ry: t4_ry_q};

  // Carry the projected result alongside the second divider
  always_ff @(posedge clk_i) begin
    sb3_q[0] <= sb3_in;
    for (int k = 1; k < prp_pkg::DIV_LAT; k++) begin
      sb3_q[k] <= sb3_q[k-1];
    end
  end

  assign sb3_out = sb3_q[prp_pkg::DIV_LAT-1];

  // Select the result and status
  always_comb begin
    if (sb3_out.zero) begin
      res_x_d  = '0;
      res_y_d  = '0;
      status_d = prp_pkg::ST_ZERO;
    end else if (sb3_out.act == prp_pkg::ACT_PROJECT) begin
      res_x_d  = sb3_out.rx;
      res_y_d  = sb3_out.ry;
      status_d = sb3_out.sat ? prp_pkg::ST_SAT : prp_pkg::ST_OK;
    end else begin
      res_x_d  = q2x;
      res_y_d  = q2y;
      status_d = (sb3_out.sat | q2sx | q2sy) ? prp_pkg::ST_SAT : prp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= q2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_x_q  <= res_x_d;
    res_y_q  <= res_y_d;
    status_q <= status_d;
  end

  assign done_o     = done_q;
  assign result_x_o = res_x_q;
  assign result_y_o = res_y_q;
  assign status_o   = status_q;

`ifndef SYNTH
  // Every transfer comes out after the fixed pipeline depth
  a_start_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##(prp_pkg::TOTAL_LAT) done_o)
    else $error("pinhole_radial_projection: result missing");

  // No result appears without a transfer that caused it
  a_done_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, prp_pkg::TOTAL_LAT))
    else $error("pinhole_radial_projection: spurious result");
`endif

endmodule
